// File: hdl/bfsa_pkg.sv
// ----------------------------------------------------------------------------
// bfsa_pkg: shared types and constants of the bounding box fitter
// Coordinate format, derived datapath widths, item structs, register indexes
// and the operation codes of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsa_pkg;

  // Signed fixed point coordinates: COORD_BITS total, FRAC_BITS fraction bits.
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  // Target widths and centering sums need three guard bits over a coordinate.
  localparam int NUM_W  = COORD_BITS + 3;
  localparam int PROD_W = 2 * COORD_BITS;
  localparam int ACC_W  = 2 * COORD_BITS + 4;
  // Split of the offset multiplicand into a low and a high part.
  localparam int LO_W   = COORD_BITS / 2;
  localparam int HI_W   = NUM_W - LO_W;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_AREA_X_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_X_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_Y_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_Y_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFE_MARGIN = 3'd4;

  localparam logic OP_MEASURE   = 1'b0;
  localparam logic OP_TRANSFORM = 1'b1;

  typedef struct packed {
    logic                         operation;
    logic                         new_set;
    logic signed [COORD_BITS-1:0] x_in;
    logic signed [COORD_BITS-1:0] y_in;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_out;
    logic signed [COORD_BITS-1:0] y_out;
    logic                         saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    MAC_NOP,
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB,
    MAC_SUB_HI,
    MAC_ABS,
    MAC_RND_OFF,
    MAC_RND_PT
  } mac_op_t;

  typedef struct packed {
    logic    mul_en;
    mac_op_t op;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/bfsa_div.sv
// ----------------------------------------------------------------------------
// bfsa_div: iterative fixed point divider
// Computes (num << FRAC_BITS) / den truncated toward zero and saturated to a
// coordinate, one quotient bit per cycle on a shared compare and subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsa_div (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  input  wire logic signed [bfsa_pkg::NUM_W-1:0]      num,
  input  wire logic        [bfsa_pkg::COORD_BITS-1:0] den,
  output logic                                        done,
  output logic signed      [bfsa_pkg::COORD_BITS-1:0] quot
);

  import bfsa_pkg::*;

  localparam int SH    = COORD_BITS - 1 - FRAC_BITS;
  localparam int CW    = NUM_W + COORD_BITS + SH;
  localparam int CNT_W = $clog2(COORD_BITS);

  typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN, D_SIGN} dstate_t;

  dstate_t                 state_r;
  logic [NUM_W-1:0]        a_r;
  logic [COORD_BITS-1:0]   d_r;
  logic                    neg_r;
  logic [COORD_BITS-1:0]   r_r;
  logic [COORD_BITS-2:0]   low_r;
  logic [COORD_BITS-2:0]   q_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    done_r;
  logic [COORD_BITS-1:0]   quot_r;

  logic [NUM_W-1:0]        abs_num;
  logic [CW-1:0]           a_w;
  logic [CW-1:0]           d_w;
  logic                    ovf;
  logic [NUM_W-1:0]        a_sh;
  logic [COORD_BITS:0]     r2;
  logic [COORD_BITS:0]     diff;
  logic                    ge;

  always_comb begin
    abs_num = num[NUM_W-1] ? (~num + {{(NUM_W-1){1'b0}}, 1'b1}) : num;
    a_w     = CW'(a_r);
    d_w     = CW'({d_r, {SH{1'b0}}});
    // The quotient would reach 2^(COORD_BITS-1): saturate without iterating.
    ovf     = (a_w >= d_w);
    a_sh    = a_r << FRAC_BITS;
    r2      = {r_r, low_r[COORD_BITS-2]};
    diff    = r2 - {1'b0, d_r};
    ge      = (r2 >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (start) begin
            a_r     <= abs_num;
            neg_r   <= num[NUM_W-1];
            d_r     <= den;
            state_r <= D_CHK;
          end
        end
        D_CHK: begin
          if (ovf) begin
            q_r     <= '1;
            state_r <= D_SIGN;
          end else begin
            r_r     <= COORD_BITS'(a_r >> SH);
            low_r   <= a_sh[COORD_BITS-2:0];
            q_r     <= '0;
            cnt_r   <= CNT_W'(COORD_BITS - 1);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          r_r   <= ge ? diff[COORD_BITS-1:0] : r2[COORD_BITS-1:0];
          q_r   <= {q_r[COORD_BITS-3:0], ge};
          low_r <= low_r << 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_r <= D_SIGN;
          end
        end
        D_SIGN: begin
          quot_r  <= neg_r ? (~{1'b0, q_r} + {{(COORD_BITS-1){1'b0}}, 1'b1})
                           : {1'b0, q_r};
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

// File: hdl/bfsa_mac.sv
// ----------------------------------------------------------------------------
// bfsa_mac: shared multiply-accumulate and rounding unit
// A registered signed multiplier feeds a wide accumulator; the accumulator is
// then rounded half away from zero and saturated to a coordinate in two steps.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsa_mac (
  input  wire logic                                   clk,
  input  wire bfsa_pkg::mac_ctrl_t                    ctrl,
  input  wire logic signed [bfsa_pkg::COORD_BITS-1:0] mul_a,
  input  wire logic signed [bfsa_pkg::COORD_BITS-1:0] mul_b,
  input  wire logic        [bfsa_pkg::ACC_W-1:0]      load_val,
  output logic        [bfsa_pkg::COORD_BITS-1:0]      res,
  output logic                                        clip
);

  import bfsa_pkg::*;

  localparam logic [ACC_W:0]        HALF_OFF = {{ACC_W{1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [ACC_W:0]        HALF_PT  = {{ACC_W{1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [ACC_W-1:0]      ACC_ONE  = {{(ACC_W-1){1'b0}}, 1'b1};
  localparam logic [COORD_BITS-1:0] RES_ONE  = {{(COORD_BITS-1){1'b0}}, 1'b1};
  localparam logic [COORD_BITS-1:0] MAX_MAG  = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] MIN_MAG  = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]         acc_r;
  logic                     neg_r;
  logic [COORD_BITS-1:0]    rmag_r;
  logic                     clip_r;

  logic [ACC_W-1:0]         p_ext;
  logic [ACC_W-1:0]         addend;
  logic [ACC_W-1:0]         sum;
  logic                     sub;
  logic [ACC_W:0]           t;
  logic [ACC_W:0]           sh;
  logic [COORD_BITS-1:0]    limit;
  logic                     over;

  always_comb begin
    p_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    if (ctrl.op == MAC_SUB_HI) begin
      p_ext = p_ext << LO_W;
    end
    sub    = ctrl.op inside {MAC_SUB, MAC_SUB_HI};
    addend = sub ? ~p_ext : p_ext;
    sum    = acc_r + addend + {{(ACC_W-1){1'b0}}, sub};

    // After the magnitude step the accumulator holds |value| as unsigned.
    t      = {1'b0, acc_r} + ((ctrl.op == MAC_RND_OFF) ? HALF_OFF : HALF_PT);
    sh     = (ctrl.op == MAC_RND_OFF) ? (t >> (FRAC_BITS + 1)) : (t >> FRAC_BITS);
    limit  = neg_r ? MIN_MAG : MAX_MAG;
    over   = (sh[ACC_W:COORD_BITS] != '0) || (sh[COORD_BITS-1:0] > limit);
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    case (ctrl.op)
      MAC_LOAD: begin
        acc_r <= load_val;
      end
      MAC_ADD, MAC_SUB, MAC_SUB_HI: begin
        acc_r <= sum;
      end
      MAC_ABS: begin
        neg_r <= acc_r[ACC_W-1];
        acc_r <= acc_r[ACC_W-1] ? (~acc_r + ACC_ONE) : acc_r;
      end
      MAC_RND_OFF, MAC_RND_PT: begin
        rmag_r <= over ? limit : sh[COORD_BITS-1:0];
        clip_r <= over;
      end
      default: begin
      end
    endcase
  end

  assign res  = neg_r ? (~rmag_r + RES_ONE) : rmag_r;
  assign clip = clip_r;

endmodule

`default_nettype wire

// File: hdl/bbox_fit_scale_to_area.sv
// ----------------------------------------------------------------------------
// bbox_fit_scale_to_area: two-pass point fitter in signed fixed point
// Measure items grow a bounding box; transform items fit the box into the
// work area with one uniform scale and centering offsets, then map the point.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake              Payload                      Direction
//   in_      in_valid / in_ready    in_data   (in_item_t)        into block
//   out_     out_valid / out_ready  out_data  (out_item_t)       out of block
//   cfg_     cfg_valid / cfg_ready  cfg_index, cfg_data          into block
//
// A measure item gives no result and leaves the sequencer idle. A transform item
// with a current fit runs the sequencer through S_PT0 to S_PT4 for each axis
// (two multiply, accumulate and round passes on the shared multiplier) and
// S_DONE, and no new item is taken until it is back in S_IDLE. The first
// transform after a measure or a register write refits first: setup states
// S_PREP0 and S_PREP1, the two ratio divisions (one quotient bit a cycle on the
// divider; a saturating ratio skips the iteration) and the two offsets. Reset is
// synchronous and active low; it empties the box, drops the fit and loads
// the default work area. The result sits in an output register, so a
// stalled output only holds the sequencer once the next result is finished.
// ----------------------------------------------------------------------------
`default_nettype none

module bbox_fit_scale_to_area (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire bfsa_pkg::in_item_t                     in_data,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output bfsa_pkg::out_item_t                         out_data,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [bfsa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [bfsa_pkg::COORD_BITS-1:0]        cfg_data
);

  import bfsa_pkg::*;

  localparam logic [COORD_BITS:0]   ONE_EXT      = {{COORD_BITS{1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [COORD_BITS-1:0] ONE          = ONE_EXT[COORD_BITS-1:0];
  localparam logic [COORD_BITS-1:0] AREA_MAX_RST = COORD_BITS'(200) << FRAC_BITS;
  localparam logic [COORD_BITS-2:0] MARGIN_RST   = (COORD_BITS-1)'(5) << FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PREP0,
    S_PREP1,
    S_DIVX,
    S_WAITX,
    S_DIVY,
    S_WAITY,
    S_OFF0,
    S_OFF1,
    S_OFF2,
    S_OFF3,
    S_OFF4,
    S_OFF5,
    S_PT0,
    S_PT1,
    S_PT2,
    S_PT3,
    S_PT4,
    S_DONE
  } state_t;

  state_t                       state_r;
  logic                         axis_r;

  // Configuration registers.
  logic [COORD_BITS-1:0]        area_x_min_r;
  logic [COORD_BITS-1:0]        area_x_max_r;
  logic [COORD_BITS-1:0]        area_y_min_r;
  logic [COORD_BITS-1:0]        area_y_max_r;
  logic [COORD_BITS-2:0]        safe_margin_r;

  // Bounding box and fit.
  logic signed [COORD_BITS-1:0] box_x_low_r;
  logic signed [COORD_BITS-1:0] box_x_high_r;
  logic signed [COORD_BITS-1:0] box_y_low_r;
  logic signed [COORD_BITS-1:0] box_y_high_r;
  logic                         box_has_point_r;
  logic                         fit_ready_r;
  logic signed [COORD_BITS-1:0] fit_scale_r;
  logic [COORD_BITS-1:0]        offset_x_r;
  logic [COORD_BITS-1:0]        offset_y_r;

  // Working registers of one item.
  logic [COORD_BITS-1:0]        x_r;
  logic [COORD_BITS-1:0]        y_r;
  logic [COORD_BITS-1:0]        w_r;
  logic [COORD_BITS-1:0]        h_r;
  logic [NUM_W-1:0]             tw_r;
  logic [NUM_W-1:0]             th_r;
  logic [NUM_W-1:0]             mx_r;
  logic [NUM_W-1:0]             my_r;
  logic signed [COORD_BITS-1:0] sx_r;
  logic [COORD_BITS-1:0]        xo_r;
  logic [COORD_BITS-1:0]        yo_r;
  logic                         clip_r;
  logic                         out_valid_r;
  out_item_t                    out_data_r;

  logic                         in_acc;
  logic                         cfg_acc;
  logic                         restart;
  logic [COORD_BITS:0]          diff_x;
  logic [COORD_BITS:0]          diff_y;
  logic [COORD_BITS-1:0]        w_calc;
  logic [COORD_BITS-1:0]        h_calc;
  logic [NUM_W-1:0]             tw_calc;
  logic [NUM_W-1:0]             th_calc;
  logic [NUM_W-1:0]             m_sel;
  logic [NUM_W-1:0]             sum_sel;
  logic [COORD_BITS-1:0]        off_sel;

  logic                         div_start;
  logic signed [NUM_W-1:0]      div_num;
  logic [COORD_BITS-1:0]        div_den;
  logic                         div_done;
  logic signed [COORD_BITS-1:0] div_quot;

  mac_ctrl_t                    mac_ctrl;
  logic signed [COORD_BITS-1:0] mul_a;
  logic [ACC_W-1:0]             load_val;
  logic [COORD_BITS-1:0]        mac_res;
  logic                         mac_clip;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new set, or the first point ever, starts the box at the point.
  assign restart = in_data.new_set || !box_has_point_r;

  always_comb begin
    // The box never inverts, so the extents are never negative.
    diff_x  = {box_x_high_r[COORD_BITS-1], box_x_high_r}
            - {box_x_low_r[COORD_BITS-1], box_x_low_r};
    diff_y  = {box_y_high_r[COORD_BITS-1], box_y_high_r}
            - {box_y_low_r[COORD_BITS-1], box_y_low_r};
    w_calc  = (diff_x < ONE_EXT) ? ONE : diff_x[COORD_BITS-1:0];
    h_calc  = (diff_y < ONE_EXT) ? ONE : diff_y[COORD_BITS-1:0];
    // Target extent: area span less the margin on both sides.
    tw_calc = {{3{area_x_max_r[COORD_BITS-1]}}, area_x_max_r}
            - {{3{area_x_min_r[COORD_BITS-1]}}, area_x_min_r}
            - NUM_W'({safe_margin_r, 1'b0});
    th_calc = {{3{area_y_max_r[COORD_BITS-1]}}, area_y_max_r}
            - {{3{area_y_min_r[COORD_BITS-1]}}, area_y_min_r}
            - NUM_W'({safe_margin_r, 1'b0});
  end

  // The centering numerator 2*(min+margin)+target reduces to min+max.
  always_comb begin
    m_sel   = axis_r ? my_r : mx_r;
    off_sel = axis_r ? offset_y_r : offset_x_r;
    if (axis_r) begin
      sum_sel = {{3{area_y_min_r[COORD_BITS-1]}}, area_y_min_r}
              + {{3{area_y_max_r[COORD_BITS-1]}}, area_y_max_r};
    end else begin
      sum_sel = {{3{area_x_min_r[COORD_BITS-1]}}, area_x_min_r}
              + {{3{area_x_max_r[COORD_BITS-1]}}, area_x_max_r};
    end
  end

  assign div_start = (state_r == S_DIVX) || (state_r == S_DIVY);
  assign div_num   = (state_r == S_DIVY) ? th_r : tw_r;
  assign div_den   = (state_r == S_DIVY) ? h_r : w_r;

  // Offset: load (min+max) << F, subtract (2*low+ext)*s in two partial
  // products, then round by F+1 bits. Point: load off << F, add p*s, round.
  always_comb begin
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.op     = MAC_NOP;
    mul_a           = axis_r ? y_r : x_r;
    load_val        = '0;
    case (state_r)
      S_OFF0: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.op     = MAC_LOAD;
        mul_a           = {{(COORD_BITS-LO_W){1'b0}}, m_sel[LO_W-1:0]};
        load_val        = {{(ACC_W-NUM_W){sum_sel[NUM_W-1]}}, sum_sel} << FRAC_BITS;
      end
      S_OFF1: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.op     = MAC_SUB;
        mul_a           = {{(COORD_BITS-HI_W){m_sel[NUM_W-1]}}, m_sel[NUM_W-1:LO_W]};
      end
      S_OFF2: begin
        mac_ctrl.op = MAC_SUB_HI;
      end
      S_OFF3, S_PT2: begin
        mac_ctrl.op = MAC_ABS;
      end
      S_OFF4: begin
        mac_ctrl.op = MAC_RND_OFF;
      end
      S_PT0: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.op     = MAC_LOAD;
        load_val        = {{(ACC_W-COORD_BITS){off_sel[COORD_BITS-1]}}, off_sel}
                          << FRAC_BITS;
      end
      S_PT1: begin
        mac_ctrl.op = MAC_ADD;
      end
      S_PT3: begin
        mac_ctrl.op = MAC_RND_PT;
      end
      default: begin
      end
    endcase
  end

  bfsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  bfsa_mac u_mac (
    .clk      (clk),
    .ctrl     (mac_ctrl),
    .mul_a    (mul_a),
    .mul_b    (fit_scale_r),
    .load_val (load_val),
    .res      (mac_res),
    .clip     (mac_clip)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      axis_r          <= 1'b0;
      out_valid_r     <= 1'b0;
      area_x_min_r    <= '0;
      area_x_max_r    <= AREA_MAX_RST;
      area_y_min_r    <= '0;
      area_y_max_r    <= AREA_MAX_RST;
      safe_margin_r   <= MARGIN_RST;
      box_x_low_r     <= '0;
      box_x_high_r    <= '0;
      box_y_low_r     <= '0;
      box_y_high_r    <= '0;
      box_has_point_r <= 1'b0;
      fit_ready_r     <= 1'b0;
      fit_scale_r     <= '0;
      offset_x_r      <= '0;
      offset_y_r      <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      // Any write to a known register invalidates the fit.
      if (cfg_acc) begin
        case (cfg_index)
          CFG_AREA_X_MIN: begin
            area_x_min_r <= cfg_data;
            fit_ready_r  <= 1'b0;
          end
          CFG_AREA_X_MAX: begin
            area_x_max_r <= cfg_data;
            fit_ready_r  <= 1'b0;
          end
          CFG_AREA_Y_MIN: begin
            area_y_min_r <= cfg_data;
            fit_ready_r  <= 1'b0;
          end
          CFG_AREA_Y_MAX: begin
            area_y_max_r <= cfg_data;
            fit_ready_r  <= 1'b0;
          end
          CFG_SAFE_MARGIN: begin
            safe_margin_r <= cfg_data[COORD_BITS-2:0];
            fit_ready_r   <= 1'b0;
          end
          default: begin
          end
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            x_r    <= in_data.x_in;
            y_r    <= in_data.y_in;
            clip_r <= 1'b0;
            axis_r <= 1'b0;
            if (in_data.operation == OP_MEASURE) begin
              if (restart || (in_data.x_in < box_x_low_r)) begin
                box_x_low_r <= in_data.x_in;
              end
              if (restart || (in_data.x_in > box_x_high_r)) begin
                box_x_high_r <= in_data.x_in;
              end
              if (restart || (in_data.y_in < box_y_low_r)) begin
                box_y_low_r <= in_data.y_in;
              end
              if (restart || (in_data.y_in > box_y_high_r)) begin
                box_y_high_r <= in_data.y_in;
              end
              box_has_point_r <= 1'b1;
              fit_ready_r     <= 1'b0;
            end else begin
              state_r <= fit_ready_r ? S_PT0 : S_PREP0;
            end
          end
        end
        S_PREP0: begin
          w_r     <= w_calc;
          h_r     <= h_calc;
          tw_r    <= tw_calc;
          th_r    <= th_calc;
          state_r <= S_PREP1;
        end
        S_PREP1: begin
          // Centering multiplicand 2*low + extent for each axis.
          mx_r    <= {{2{box_x_low_r[COORD_BITS-1]}}, box_x_low_r, 1'b0}
                   + {3'b000, w_r};
          my_r    <= {{2{box_y_low_r[COORD_BITS-1]}}, box_y_low_r, 1'b0}
                   + {3'b000, h_r};
          state_r <= S_DIVX;
        end
        S_DIVX: begin
          state_r <= S_WAITX;
        end
        S_WAITX: begin
          if (div_done) begin
            sx_r    <= div_quot;
            state_r <= S_DIVY;
          end
        end
        S_DIVY: begin
          state_r <= S_WAITY;
        end
        S_WAITY: begin
          if (div_done) begin
            fit_scale_r <= (sx_r < div_quot) ? sx_r : div_quot;
            state_r     <= S_OFF0;
          end
        end
        S_OFF0: begin
          state_r <= S_OFF1;
        end
        S_OFF1: begin
          state_r <= S_OFF2;
        end
        S_OFF2: begin
          state_r <= S_OFF3;
        end
        S_OFF3: begin
          state_r <= S_OFF4;
        end
        S_OFF4: begin
          state_r <= S_OFF5;
        end
        S_OFF5: begin
          if (!axis_r) begin
            offset_x_r <= mac_res;
            axis_r     <= 1'b1;
            state_r    <= S_OFF0;
          end else begin
            offset_y_r  <= mac_res;
            axis_r      <= 1'b0;
            fit_ready_r <= 1'b1;
            state_r     <= S_PT0;
          end
        end
        S_PT0: begin
          state_r <= S_PT1;
        end
        S_PT1: begin
          state_r <= S_PT2;
        end
        S_PT2: begin
          state_r <= S_PT3;
        end
        S_PT3: begin
          state_r <= S_PT4;
        end
        S_PT4: begin
          clip_r <= clip_r | mac_clip;
          if (!axis_r) begin
            xo_r    <= mac_res;
            axis_r  <= 1'b1;
            state_r <= S_PT0;
          end else begin
            yo_r    <= mac_res;
            axis_r  <= 1'b0;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // Wait only while the previous result still sits unclaimed.
          if (!out_valid_r || out_ready) begin
            out_data_r.x_out     <= xo_r;
            out_data_r.y_out     <= yo_r;
            out_data_r.saturated <= clip_r;
            out_valid_r          <= 1'b1;
            state_r              <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The divider only reports back while the sequencer waits on it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_WAITX || state_r == S_WAITY))
    else $error("divider finished outside a wait state");

  // Points are mapped only with a valid fit in place.
  a_fit_before_map: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PT0) |-> fit_ready_r)
    else $error("point mapping started without a fit");

  // A result appears only as the end of a transform item.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside the final state");

endmodule

`default_nettype wire

// File: tb/bbox_fit_scale_to_area_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bbox_fit_scale_to_area_tb: self-checking bench for the bounding box fitter
// Drives measure and transform items through a valid/ready channel and writes
// the work area registers between phases. A fixed point predictor of the box,
// the fit and the point mapping runs on every accepted item. Each result is
// checked field by field in order. Both sides idle at random, and there is a
// long output stall and a full drain along the way.
// ----------------------------------------------------------------------------

module bbox_fit_scale_to_area_tb;

  import bfsa_pkg::*;

  // An index outside the register map. A write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // Handy coordinates in Q16.16.
  localparam logic [COORD_BITS-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [COORD_BITS-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_BITS-1:0] MM_ONE    = 32'h0001_0000;

  localparam int ITEM_TARGET = 1100;
  localparam int STALL_CYCLES = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES = 150;

  // Wide signed type for exact products and centering sums.
  typedef logic signed [127:0] wide_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [COORD_BITS-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  bbox_fit_scale_to_area dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state. The work area starts at 0..200 mm on both axes with a
  // 5 mm margin, the box is empty and no fit is held.
  // --------------------------------------------------------------------------
  longint area_x_lo = 0;
  longint area_x_hi = 200 * 65536;
  longint area_y_lo = 0;
  longint area_y_hi = 200 * 65536;
  longint margin_v  = 5 * 65536;

  longint bb_x_lo = 0, bb_x_hi = 0, bb_y_lo = 0, bb_y_hi = 0;
  bit     box_seen = 1'b0;
  bit     fit_known = 1'b0;
  longint scale_q = 0, ofs_x = 0, ofs_y = 0;

  // Fitted points still owed by the block, oldest first.
  out_item_t fitted_q[$];

  int  accepted_items = 0;
  int  mismatches = 0;
  // When set, neither side idles.
  bit  quiet = 1'b0;
  // Each increment asks the receiver for one long stall.
  int  stall_reqs = 0;

  // Divide by 2^k with ties away from zero and clip to the coordinate range.
  function automatic longint round_coord(input wide_t v, input int k, inout bit clip);
    wide_t  m;
    bit     neg;
    longint lim;
    neg = v[127];
    m = neg ? -v : v;
    m = (m + (wide_t'(1) << (k - 1))) >> k;
    lim = neg ? (longint'(1) << (COORD_BITS - 1)) : ((longint'(1) << (COORD_BITS - 1)) - 1);
    if (m > wide_t'(lim)) begin
      clip = 1'b1;
      m = wide_t'(lim);
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Ratio of target to extent in Q16.16, truncated toward zero and clipped to
  // the largest coordinate magnitude. The extent is always at least 1.0.
  function automatic longint ratio_q(input longint num, input longint den);
    longint a;
    longint q;
    longint qmax;
    qmax = (longint'(1) << (COORD_BITS - 1)) - 1;
    a = (num < 0) ? -num : num;
    q = (a << FRAC_BITS) / den;
    if (q > qmax) q = qmax;
    return (num < 0) ? -q : q;
  endfunction

  // Centering offset: half of (2*(amin+margin) + target - (2*lo + extent)*s),
  // rounded once.
  function automatic longint centre_offset(input longint amin, input longint lo,
                                           input longint ext, input longint tgt);
    wide_t n;
    bit    unused_clip;
    unused_clip = 1'b0;
    n = (wide_t'(2 * (amin + margin_v) + tgt) << FRAC_BITS)
        - wide_t'(2 * lo + ext) * wide_t'(scale_q);
    return round_coord(n, FRAC_BITS + 1, unused_clip);
  endfunction

  // Fit the current box into the work area. An empty box counts as a point at
  // the origin, and each extent is raised to at least 1.0 mm.
  function automatic void refit_scale();
    longint xl, xh, yl, yh, w, h, tw, th, sx, sy;
    xl = box_seen ? bb_x_lo : 0;
    xh = box_seen ? bb_x_hi : 0;
    yl = box_seen ? bb_y_lo : 0;
    yh = box_seen ? bb_y_hi : 0;
    w = xh - xl;
    h = yh - yl;
    if (w < 65536) w = 65536;
    if (h < 65536) h = 65536;
    // A margin wider than half the area leaves a negative target, which is
    // used as it is.
    tw = (area_x_hi - area_x_lo) - 2 * margin_v;
    th = (area_y_hi - area_y_lo) - 2 * margin_v;
    sx = ratio_q(tw, w);
    sy = ratio_q(th, h);
    scale_q = (sx < sy) ? sx : sy;
    ofs_x = centre_offset(area_x_lo, xl, w, tw);
    ofs_y = centre_offset(area_y_lo, yl, h, th);
    fit_known = 1'b1;
  endfunction

  // Apply one accepted item to the predictor.
  function automatic void fit_item(input in_item_t it);
    longint    px, py, xo, yo;
    bit        clip;
    out_item_t res;
    px = longint'(signed'(it.x_in));
    py = longint'(signed'(it.y_in));
    if (it.operation == OP_MEASURE) begin
      // The very first measure starts the box even without new_set.
      if (it.new_set || !box_seen) begin
        bb_x_lo = px;
        bb_x_hi = px;
        bb_y_lo = py;
        bb_y_hi = py;
      end else begin
        if (px < bb_x_lo) bb_x_lo = px;
        if (px > bb_x_hi) bb_x_hi = px;
        if (py < bb_y_lo) bb_y_lo = py;
        if (py > bb_y_hi) bb_y_hi = py;
      end
      box_seen = 1'b1;
      fit_known = 1'b0;
    end else begin
      if (!fit_known) refit_scale();
      clip = 1'b0;
      xo = round_coord(wide_t'(px) * wide_t'(scale_q) + (wide_t'(ofs_x) << FRAC_BITS),
                       FRAC_BITS, clip);
      yo = round_coord(wide_t'(py) * wide_t'(scale_q) + (wide_t'(ofs_y) << FRAC_BITS),
                       FRAC_BITS, clip);
      res.x_out = xo[COORD_BITS-1:0];
      res.y_out = yo[COORD_BITS-1:0];
      res.saturated = clip;
      fitted_q.push_back(res);
    end
  endfunction

  function automatic in_item_t make_item(input logic op, input logic ns,
                                         input logic [COORD_BITS-1:0] x,
                                         input logic [COORD_BITS-1:0] y);
    in_item_t it;
    it.operation = op;
    it.new_set = ns;
    it.x_in = x;
    it.y_in = y;
    return it;
  endfunction

  // Coordinates by class: a sub-millimetre cluster, a drawing-sized spread, the
  // full range, or one of the range corners.
  function automatic logic [COORD_BITS-1:0] pick_coord(input int unsigned cls,
                                                      input logic [COORD_BITS-1:0] base);
    case (cls)
      0: return base + $urandom_range(0, 40000);
      1: return base + $urandom_range(0, 26214400);
      2: return $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Valid goes up at a falling edge and stays up until the item is
  // taken; the next call either drives the next item or idles first.
  // --------------------------------------------------------------------------
  task automatic send_item(input in_item_t it);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accepted_items++;
    fit_item(it);
  endtask

  // Stop offering items and wait until every fitted point has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (fitted_q.size() != 0) @(posedge clk);
  endtask

  // A measure item gives no result. Drain the results, then let SETTLE_CYCLES
  // pass before touching registers.
  task automatic settle_idle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [COORD_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_AREA_X_MIN:  area_x_lo = longint'(signed'(data));
      CFG_AREA_X_MAX:  area_x_hi = longint'(signed'(data));
      CFG_AREA_Y_MIN:  area_y_lo = longint'(signed'(data));
      CFG_AREA_Y_MAX:  area_y_hi = longint'(signed'(data));
      CFG_SAFE_MARGIN: margin_v = longint'(data[COORD_BITS-2:0]);
      default: ;
    endcase
    // Only a real register drops the fit.
    if (idx <= CFG_SAFE_MARGIN) fit_known = 1'b0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_area(input logic [COORD_BITS-1:0] xl, input logic [COORD_BITS-1:0] xh,
                            input logic [COORD_BITS-1:0] yl, input logic [COORD_BITS-1:0] yh,
                            input logic [COORD_BITS-1:0] mg);
    write_reg(CFG_AREA_X_MIN, xl);
    write_reg(CFG_AREA_X_MAX, xh);
    write_reg(CFG_AREA_Y_MIN, yl);
    write_reg(CFG_AREA_Y_MAX, yh);
    write_reg(CFG_SAFE_MARGIN, mg);
  endtask

  // --------------------------------------------------------------------------
  // Receiver. Ready changes at the falling edge. A long stall, once asked for,
  // is counted down here so the sender can keep pushing in the meantime.
  // --------------------------------------------------------------------------
  int stalls_done = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    if (stall_reqs != stalls_done) begin
      stalls_done = stall_reqs;
      hold_left = STALL_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 8);
    end
  end

  // Every result taken is compared with the oldest fitted point still owed.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (fitted_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result x_out %h y_out %h saturated %b",
                 $time, out_data.x_out, out_data.y_out, out_data.saturated);
      end else begin
        want = fitted_q.pop_front();
        if (out_data.x_out !== want.x_out) begin
          mismatches++;
          $display("%0t x_out mismatch: expected %h actual %h",
                   $time, want.x_out, out_data.x_out);
        end
        if (out_data.y_out !== want.y_out) begin
          mismatches++;
          $display("%0t y_out mismatch: expected %h actual %h",
                   $time, want.y_out, out_data.y_out);
        end
        if (out_data.saturated !== want.saturated) begin
          mismatches++;
          $display("%0t saturated mismatch: expected %b actual %b",
                   $time, want.saturated, out_data.saturated);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Transforms straight after reset fit an empty box: a 1 mm square at the
  // origin, so the scale is large and the corners clip.
  task automatic test_empty_box();
    send_item(make_item(OP_TRANSFORM, 1'b0, '0, '0));
    send_item(make_item(OP_TRANSFORM, 1'b1, COORD_MAX, COORD_MAX));
    send_item(make_item(OP_TRANSFORM, 1'b0, COORD_MIN, COORD_MIN));
  endtask

  // The first measure starts the box even with new_set low.
  task automatic test_first_measure();
    send_item(make_item(OP_MEASURE, 1'b0, 32'h0014_8000, 32'hFFF0_0000));
    send_item(make_item(OP_MEASURE, 1'b0, 32'h0050_0000, 32'h0030_0000));
    send_item(make_item(OP_TRANSFORM, 1'b0, 32'h0014_8000, 32'hFFF0_0000));
    send_item(make_item(OP_TRANSFORM, 1'b1, 32'h0030_0000, 32'h0008_0000));
  endtask

  // A box spanning the whole coordinate range gives the smallest scale.
  task automatic test_box_extremes();
    send_item(make_item(OP_MEASURE, 1'b1, COORD_MIN, COORD_MIN));
    send_item(make_item(OP_MEASURE, 1'b0, COORD_MAX, COORD_MAX));
    send_item(make_item(OP_TRANSFORM, 1'b0, COORD_MIN, COORD_MAX));
    send_item(make_item(OP_TRANSFORM, 1'b0, COORD_MAX, COORD_MIN));
    send_item(make_item(OP_TRANSFORM, 1'b0, '0, '0));
  endtask

  // Register writes drop the fit, so the next transform refits the same box.
  // Covers a margin wider than half the area, the widest area, a margin with the
  // unused top data bit set, a write to an unmapped index, and the defaults.
  task automatic test_register_refit();
    send_item(make_item(OP_MEASURE, 1'b1, 32'h000A_0000, 32'h0014_0000));
    send_item(make_item(OP_MEASURE, 1'b0, 32'h003C_0000, 32'h005A_0000));
    settle_idle();
    write_reg(CFG_SAFE_MARGIN, 32'h0096_0000);
    send_item(make_item(OP_TRANSFORM, 1'b0, 32'h000A_0000, 32'h0014_0000));
    send_item(make_item(OP_TRANSFORM, 1'b0, 32'h003C_0000, 32'h005A_0000));
    settle_idle();
    write_area(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, '0);
    send_item(make_item(OP_TRANSFORM, 1'b0, 32'h000A_0000, 32'h005A_0000));
    send_item(make_item(OP_TRANSFORM, 1'b0, COORD_MAX, COORD_MIN));
    settle_idle();
    write_reg(CFG_SAFE_MARGIN, 32'hFFFF_FFFF);
    send_item(make_item(OP_TRANSFORM, 1'b0, 32'h0020_0000, 32'h0030_0000));
    settle_idle();
    write_reg(CFG_UNUSED, 32'h1234_5678);
    send_item(make_item(OP_TRANSFORM, 1'b0, 32'h0020_0000, 32'h0030_0000));
    settle_idle();
    write_area('0, 32'h00C8_0000, '0, 32'h00C8_0000, 32'h0005_0000);
    send_item(make_item(OP_MEASURE, 1'b1, 32'hFFE2_0000, 32'h0100_0000));
    send_item(make_item(OP_TRANSFORM, 1'b0, 32'h0000_0000, 32'h0000_0000));
  endtask

  // One drawing: a restart, a few more measures, then its points mapped.
  task automatic send_drawing(input int n_meas, input int n_pts);
    int unsigned           cls;
    logic [COORD_BITS-1:0] base_x, base_y;
    logic                  ns;
    cls = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(0, 3);
    base_x = $urandom_range(0, 26214400) - 13107200;
    base_y = $urandom_range(0, 26214400) - 13107200;
    send_item(make_item(OP_MEASURE, 1'b1, pick_coord(cls, base_x), pick_coord(cls, base_y)));
    repeat (n_meas) begin
      ns = ($urandom_range(0, 15) == 0);
      send_item(make_item(OP_MEASURE, ns, pick_coord(cls, base_x), pick_coord(cls, base_y)));
    end
    repeat (n_pts) begin
      send_item(make_item(OP_TRANSFORM, $urandom_range(0, 1),
                          pick_coord(cls, base_x), pick_coord(cls, base_y)));
    end
  endtask

  // The receiver stops for a long while as transforms keep coming, so the
  // output register and the sequencer fill and the input stalls.
  task automatic test_backpressure();
    send_drawing(3, 0);
    stall_reqs++;
    quiet = 1'b1;
    repeat (24) begin
      send_item(make_item(OP_TRANSFORM, 1'b0, pick_coord(1, '0), pick_coord(1, '0)));
    end
    quiet = 1'b0;
  endtask

  // The sender pauses until every result is back, then carries on.
  task automatic test_drain_pause();
    send_drawing(4, 6);
    drain_results();
    send_item(make_item(OP_TRANSFORM, 1'b0, pick_coord(1, '0), pick_coord(1, '0)));
    send_drawing(2, 3);
  endtask

  // New work area between phases, chosen among sensible drawing areas, random
  // words, margins wider than half the area, the widest area and reversed edges.
  task automatic random_config();
    logic [COORD_BITS-1:0] xl, yl;
    settle_idle();
    xl = $urandom_range(0, 26214400) - 13107200;
    yl = $urandom_range(0, 26214400) - 13107200;
    case ($urandom_range(0, 5))
      0, 1: write_area(xl, xl + ($urandom_range(20, 400) << 16),
                       yl, yl + ($urandom_range(20, 400) << 16),
                       $urandom_range(0, 10) << 16);
      2: write_area($urandom, $urandom, $urandom, $urandom, $urandom);
      3: write_area(xl, xl + ($urandom_range(10, 100) << 16),
                    yl, yl + ($urandom_range(10, 100) << 16),
                    $urandom_range(60, 200) << 16);
      4: write_area(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, $urandom_range(0, 1));
      default: begin
        // Only one register changes; that alone must force a refit.
        case ($urandom_range(0, 4))
          0: write_reg(CFG_AREA_X_MIN, xl);
          1: write_reg(CFG_AREA_X_MAX, xl + ($urandom_range(0, 800) << 16));
          2: write_reg(CFG_AREA_Y_MIN, yl);
          3: write_reg(CFG_AREA_Y_MAX, yl - ($urandom_range(0, 50) << 16));
          default: write_reg(CFG_SAFE_MARGIN, $urandom);
        endcase
      end
    endcase
  endtask

  // Mostly whole drawings with random content; some loose noise, runs of
  // transforms on a held fit, and register changes. One stretch in the middle
  // runs with no idling on either side.
  task automatic test_random_sets();
    int unsigned kind;
    while (accepted_items < ITEM_TARGET) begin
      quiet = (accepted_items >= 500 && accepted_items < 650);
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        send_drawing($urandom_range(1, 6), $urandom_range(1, 8));
      end else if (kind < 16) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(make_item($urandom_range(0, 1), $urandom_range(0, 1),
                              pick_coord($urandom_range(0, 3), $urandom),
                              pick_coord($urandom_range(0, 3), $urandom)));
        end
      end else if (kind < 18) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(make_item(OP_TRANSFORM, $urandom_range(0, 1),
                              pick_coord(1, '0), pick_coord(1, '0)));
        end
      end else begin
        quiet = 1'b0;
        random_config();
      end
    end
    quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_box();
    test_first_measure();
    test_box_extremes();
    test_register_refit();
    test_backpressure();
    test_drain_pause();
    test_random_sets();

    drain_results();
    // Leave room for any stray result to show up.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS bbox_fit_scale_to_area");
    end else begin
      $display("FAIL bbox_fit_scale_to_area");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("FAIL bbox_fit_scale_to_area");
    $finish;
  end

endmodule
